// ===== design/kbe_pkg.sv =====
// ---------------------------------------------------------------------------
// kbe_pkg
// Shared types, constants and state encoding of the accelerometer bias
// estimator.
// ---------------------------------------------------------------------------
package kbe_pkg;

   localparam int ACCEL_WIDTH = 24;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int COV_WIDTH = 32;
   localparam int TRACE_WIDTH = 34;
   localparam int GRAV_WIDTH = 15;
   localparam int RCOEF_WIDTH = 24;
   localparam int GAIN_WIDTH = 25;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_R_BASE        = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_R_GAIN        = 4'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GRAVITY       = 4'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROCESS_NOISE = 4'd3;

   localparam logic [RCOEF_WIDTH-1:0] R_BASE_RESET  = 24'd1000;
   localparam logic [RCOEF_WIDTH-1:0] R_GAIN_RESET  = 24'd1000000;
   localparam logic [GRAV_WIDTH-1:0]  GRAVITY_RESET = 15'd10045;
   localparam logic [COV_WIDTH-1:0]   PNOISE_RESET  = 32'h0100_0000;
   localparam logic [COV_WIDTH-1:0]   COV_RESET     = 32'h0100_0000;

   typedef struct packed {
      logic [63:0]                    sample_time;
      logic signed [ACCEL_WIDTH-1:0]  accel_x;
      logic signed [ACCEL_WIDTH-1:0]  accel_y;
      logic signed [ACCEL_WIDTH-1:0]  accel_z;
   } req_type;

   typedef struct packed {
      logic                           updated;
      logic signed [ACCEL_WIDTH-1:0]  bias_x;
      logic signed [ACCEL_WIDTH-1:0]  bias_y;
      logic signed [ACCEL_WIDTH-1:0]  bias_z;
      logic [TRACE_WIDTH-1:0]         cov_trace;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_GO,
      ST_SQ_WAIT,
      ST_RT_GO,
      ST_RT_WAIT,
      ST_RM_GO,
      ST_RM_WAIT,
      ST_DV_GO,
      ST_DV_WAIT,
      ST_UP_GO,
      ST_UP_WAIT,
      ST_WRITE,
      ST_OUT
   } state_type;

endpackage

// ===== design/kbe_shift_mul.sv =====
// ---------------------------------------------------------------------------
// kbe_shift_mul
// Unsigned bit-serial shift-add multiplier, one multiplier bit per cycle.
// ---------------------------------------------------------------------------
module kbe_shift_mul #(
   parameter int A_WIDTH = 24,
   parameter int B_WIDTH = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [A_WIDTH-1:0]         a,
   input  logic [B_WIDTH-1:0]         b,
   output logic [A_WIDTH+B_WIDTH-1:0] product,
   output logic                       done
);

   localparam int PW = A_WIDTH + B_WIDTH;
   localparam int CW = $clog2(B_WIDTH + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] acc_ff, acc_in;
   logic [PW-1:0] mcand_ff, mcand_in;
   logic [B_WIDTH-1:0] mplier_ff, mplier_in;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      if (start) begin
         busy_in   = 1'b1;
         count_in  = CW'(B_WIDTH);
         acc_in    = '0;
         mcand_in  = PW'(a);
         mplier_in = b;
      end else if (busy_ff) begin
         count_in  = count_ff - CW'(1);
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         if (count_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign product = acc_ff;
   assign done    = done_ff;

endmodule

// ===== design/kbe_serial_sqrt.sv =====
// ---------------------------------------------------------------------------
// kbe_serial_sqrt
// Restoring integer square root, one root bit per cycle.
// ---------------------------------------------------------------------------
module kbe_serial_sqrt #(
   parameter int ROOT_WIDTH = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [2*ROOT_WIDTH-1:0] radicand,
   output logic [ROOT_WIDTH-1:0]   root,
   output logic                    done
);

   localparam int NW = 2 * ROOT_WIDTH;
   localparam int MW = ROOT_WIDTH + 4;
   localparam int CW = $clog2(ROOT_WIDTH + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] count_ff, count_in;
   logic [NW-1:0] rad_ff, rad_in;
   logic [MW-1:0] rem_ff, rem_in;
   logic [ROOT_WIDTH-1:0] root_ff, root_in;
   logic [MW-1:0] trial_rem;
   logic [MW-1:0] trial_sub;

   always_comb begin
      trial_rem = {rem_ff[MW-3:0], rad_ff[NW-1:NW-2]};
      trial_sub = {2'b00, root_ff, 2'b01};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CW'(ROOT_WIDTH);
         rad_in   = radicand;
         rem_in   = '0;
         root_in  = '0;
      end else if (busy_ff) begin
         count_in = count_ff - CW'(1);
         rad_in   = rad_ff << 2;
         if (trial_rem >= trial_sub) begin
            rem_in  = trial_rem - trial_sub;
            root_in = {root_ff[ROOT_WIDTH-2:0], 1'b1};
         end else begin
            rem_in  = trial_rem;
            root_in = {root_ff[ROOT_WIDTH-2:0], 1'b0};
         end
         if (count_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule

// ===== design/kbe_serial_div.sv =====
// ---------------------------------------------------------------------------
// kbe_serial_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module kbe_serial_div #(
   parameter int NUM_WIDTH = 56,
   parameter int DEN_WIDTH = 63
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_WIDTH-1:0] numer,
   input  logic [DEN_WIDTH-1:0] denom,
   output logic [NUM_WIDTH-1:0] quotient,
   output logic                 done
);

   localparam int CW = $clog2(NUM_WIDTH + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [NUM_WIDTH-1:0] quo_ff, quo_in;
   logic [DEN_WIDTH-1:0] rem_ff, rem_in;
   logic [DEN_WIDTH-1:0] den_ff, den_in;
   logic [DEN_WIDTH:0]   trial;
   logic [DEN_WIDTH:0]   diff;
   logic                 fits;

   always_comb begin
      trial    = {rem_ff, quo_ff[NUM_WIDTH-1]};
      diff     = trial - {1'b0, den_ff};
      fits     = trial >= {1'b0, den_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CW'(NUM_WIDTH);
         quo_in   = numer;
         rem_in   = '0;
         den_in   = denom;
      end else if (busy_ff) begin
         count_in = count_ff - CW'(1);
         quo_in   = {quo_ff[NUM_WIDTH-2:0], fits};
         rem_in   = fits ? diff[DEN_WIDTH-1:0] : trial[DEN_WIDTH-1:0];
         if (count_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ===== design/accel_bias_kalman_estimator.sv =====
// ---------------------------------------------------------------------------
// accel_bias_kalman_estimator
// Scalar-covariance Kalman estimate of 3-axis accelerometer bias.
// ---------------------------------------------------------------------------
// One transaction in gives one transaction out. A skipped sample (first one,
// or repeated timestamp) goes straight to the output state, and its result is
// registered from there once the output register is free. An updating
// sample runs through bit-serial units in turn: the three squares, the
// magnitude square root, the noise multiply, the gain divide and the
// bias/covariance multiplies, then the write state and the output state.
// One sample is in work at a time; a finished result waits in the output
// register while the next is taken.
// ---------------------------------------------------------------------------
module accel_bias_kalman_estimator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  kbe_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output kbe_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [kbe_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [kbe_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   localparam int AW   = kbe_pkg::ACCEL_WIDTH;
   localparam int GW   = kbe_pkg::GRAV_WIDTH;
   localparam int OW   = (AW > 16 ? AW : 16) + 1;
   localparam int DW   = OW + 1;
   localparam int SW   = DW + 3;
   localparam int DEVW = (AW > GW) ? AW : GW;
   localparam int RPW  = DEVW + kbe_pkg::RCOEF_WIDTH;
   localparam int RFW  = RPW + 1;
   localparam int KW   = kbe_pkg::GAIN_WIDTH;
   localparam int NUMW = 56;
   localparam int DENW = 63;

   kbe_pkg::state_type state_ff, state_in;

   logic [23:0] r_base_ff, r_gain_ff;
   logic [GW-1:0] gravity_ff;
   logic [31:0] pnoise_ff;

   logic signed [AW-1:0] bias_ff [3];
   logic [31:0] ev_ff;
   logic [63:0] prev_time_ff;
   logic signed [AW-1:0] acc_ff [3];
   logic upd_ff;

   logic rsp_valid_ff, rsp_valid_in;
   kbe_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic req_accept, skip, out_free;
   logic sq_go, rt_go, rm_go, dv_go, up_go;
   logic sq_done, rt_done, rm_done, dv_done, up_done;
   logic [2:0] sq_done_v, up_done_v;
   logic cov_done;

   logic signed [OW-1:0] a_ext [3];
   logic signed [OW-1:0] abs_a [3];
   logic signed [OW-1:0] obs [3];
   logic signed [OW-1:0] g_ext;
   logic signed [DW-1:0] diff [3];
   logic [DW-1:0] abs_diff [3];
   logic [2*AW-1:0] sq_p [3];
   logic [2*AW-1:0] sq_sum;
   logic [AW-1:0] mag;
   logic [DEVW-1:0] mag_ext, grav_ext, dev;
   logic [RPW-1:0] r_prod;
   logic [RFW-1:0] r_full;
   logic [63:0] r_ext;
   logic [47:0] r48;
   logic [32:0] pp_sum;
   logic [31:0] pp;
   logic [DENW-1:0] den;
   logic den_zero;
   logic [NUMW-1:0] quo;
   logic [KW-1:0] k, nk;
   logic [DW+KW-1:0] b_prod [3];
   logic [DW+KW:0] b_round [3];
   logic [DW+1:0] d_mag [3];
   logic signed [SW-1:0] d_signed [3];
   logic signed [SW-1:0] b_sum [3];
   logic signed [AW-1:0] bias_new [3];
   logic [32+KW-1:0] ev_prod;
   logic [32+KW:0] ev_round;
   logic [31:0] ev_new;

   localparam logic signed [SW-1:0] BMAX = $signed({{(SW-AW+1){1'b0}}, {(AW-1){1'b1}}});
   localparam logic signed [SW-1:0] BMIN = ~BMAX;
   localparam logic [63:0] R_MAX = 64'h0000_FFFF_FFFF_FFFF;
   localparam logic [KW-1:0] K_ONE = KW'(1) << 24;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != kbe_pkg::ST_IDLE);
   assign skip       = (prev_time_ff == 64'd0) || (req_data.sample_time == prev_time_ff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;

   always_comb begin
      g_ext = $signed(OW'(gravity_ff));
      for (int i = 0; i < 3; i++) begin
         a_ext[i] = OW'(acc_ff[i]);
         abs_a[i] = a_ext[i][OW-1] ? -a_ext[i] : a_ext[i];
         obs[i]   = a_ext[i];
      end
      if (a_ext[0] > abs_a[1] && a_ext[0] > abs_a[2]) begin
         obs[0] = a_ext[0] - g_ext;
      end else if (-a_ext[0] > abs_a[1] && -a_ext[0] > abs_a[2]) begin
         obs[0] = a_ext[0] + g_ext;
      end else if (a_ext[1] > abs_a[0] && a_ext[1] > abs_a[2]) begin
         obs[1] = a_ext[1] - g_ext;
      end else if (-a_ext[1] > abs_a[0] && -a_ext[1] > abs_a[2]) begin
         obs[1] = a_ext[1] + g_ext;
      end else if (a_ext[2] > abs_a[0] && a_ext[2] > abs_a[1]) begin
         obs[2] = a_ext[2] - g_ext;
      end else begin
         obs[2] = a_ext[2] + g_ext;
      end
      for (int i = 0; i < 3; i++) begin
         diff[i]     = DW'(obs[i]) - DW'(bias_ff[i]);
         abs_diff[i] = diff[i][DW-1] ? DW'(-diff[i]) : DW'(diff[i]);
      end
   end

   assign sq_sum   = sq_p[0] + sq_p[1] + sq_p[2];
   assign mag_ext  = DEVW'(mag);
   assign grav_ext = DEVW'(gravity_ff);
   assign dev      = (mag_ext > grav_ext) ? (mag_ext - grav_ext) : (grav_ext - mag_ext);
   assign r_full   = RFW'(r_prod) + RFW'({r_base_ff, 10'b0});
   assign r_ext    = 64'(r_full);
   assign r48      = (r_ext > R_MAX) ? 48'hFFFF_FFFF_FFFF : r_ext[47:0];
   assign pp_sum   = {1'b0, ev_ff} + {1'b0, pnoise_ff};
   assign pp       = pp_sum[32] ? 32'hFFFF_FFFF : pp_sum[31:0];
   assign den      = DENW'(pp) + {1'b0, r48, 14'b0};
   assign den_zero = (pp == 32'd0) && (r48 == 48'd0);
   assign k        = den_zero ? '0 : quo[KW-1:0];
   assign nk       = K_ONE - k;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         b_round[i]  = {1'b0, b_prod[i]} + (DW+KW+1)'(24'h80_0000);
         d_mag[i]    = b_round[i][DW+KW:24];
         d_signed[i] = diff[i][DW-1] ? -$signed(SW'(d_mag[i])) : $signed(SW'(d_mag[i]));
         b_sum[i]    = SW'(bias_ff[i]) + d_signed[i];
         if (b_sum[i] > BMAX) begin
            bias_new[i] = BMAX[AW-1:0];
         end else if (b_sum[i] < BMIN) begin
            bias_new[i] = BMIN[AW-1:0];
         end else begin
            bias_new[i] = b_sum[i][AW-1:0];
         end
      end
      ev_round = {1'b0, ev_prod} + (32+KW+1)'(24'h80_0000);
      ev_new   = ev_round[55:24];
   end

   genvar gi;
   generate
      for (gi = 0; gi < 3; gi++) begin : g_lane
         kbe_shift_mul #(.A_WIDTH(AW), .B_WIDTH(AW)) u_square (
            .clock(clock), .reset(reset), .start(sq_go),
            .a(abs_a[gi][AW-1:0]), .b(abs_a[gi][AW-1:0]),
            .product(sq_p[gi]), .done(sq_done_v[gi])
         );
         kbe_shift_mul #(.A_WIDTH(DW), .B_WIDTH(KW)) u_bias_mul (
            .clock(clock), .reset(reset), .start(up_go),
            .a(abs_diff[gi]), .b(k),
            .product(b_prod[gi]), .done(up_done_v[gi])
         );
      end
   endgenerate

   assign sq_done = &sq_done_v;
   assign up_done = (&up_done_v) && cov_done;

   kbe_serial_sqrt #(.ROOT_WIDTH(AW)) u_sqrt (
      .clock(clock), .reset(reset), .start(rt_go),
      .radicand(sq_sum), .root(mag), .done(rt_done)
   );

   kbe_shift_mul #(.A_WIDTH(DEVW), .B_WIDTH(kbe_pkg::RCOEF_WIDTH)) u_noise_mul (
      .clock(clock), .reset(reset), .start(rm_go),
      .a(dev), .b(r_gain_ff), .product(r_prod), .done(rm_done)
   );

   kbe_serial_div #(.NUM_WIDTH(NUMW), .DEN_WIDTH(DENW)) u_gain_div (
      .clock(clock), .reset(reset), .start(dv_go),
      .numer({pp, 24'b0}), .denom(den), .quotient(quo), .done(dv_done)
   );

   kbe_shift_mul #(.A_WIDTH(32), .B_WIDTH(KW)) u_cov_mul (
      .clock(clock), .reset(reset), .start(up_go),
      .a(pp), .b(nk), .product(ev_prod), .done(cov_done)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kbe_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = skip ? kbe_pkg::ST_OUT : kbe_pkg::ST_SQ_GO;
            end
         end
         kbe_pkg::ST_SQ_GO:   state_in = kbe_pkg::ST_SQ_WAIT;
         kbe_pkg::ST_SQ_WAIT: if (sq_done) state_in = kbe_pkg::ST_RT_GO;
         kbe_pkg::ST_RT_GO:   state_in = kbe_pkg::ST_RT_WAIT;
         kbe_pkg::ST_RT_WAIT: if (rt_done) state_in = kbe_pkg::ST_RM_GO;
         kbe_pkg::ST_RM_GO:   state_in = kbe_pkg::ST_RM_WAIT;
         kbe_pkg::ST_RM_WAIT: if (rm_done) state_in = kbe_pkg::ST_DV_GO;
         kbe_pkg::ST_DV_GO:   state_in = kbe_pkg::ST_DV_WAIT;
         kbe_pkg::ST_DV_WAIT: if (dv_done) state_in = kbe_pkg::ST_UP_GO;
         kbe_pkg::ST_UP_GO:   state_in = kbe_pkg::ST_UP_WAIT;
         kbe_pkg::ST_UP_WAIT: if (up_done) state_in = kbe_pkg::ST_WRITE;
         kbe_pkg::ST_WRITE:   state_in = kbe_pkg::ST_OUT;
         kbe_pkg::ST_OUT:     if (out_free) state_in = kbe_pkg::ST_IDLE;
         default:             state_in = kbe_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      sq_go = 1'b0;
      rt_go = 1'b0;
      rm_go = 1'b0;
      dv_go = 1'b0;
      up_go = 1'b0;
      case (state_ff)
         kbe_pkg::ST_SQ_GO: sq_go = 1'b1;
         kbe_pkg::ST_RT_GO: rt_go = 1'b1;
         kbe_pkg::ST_RM_GO: rm_go = 1'b1;
         kbe_pkg::ST_DV_GO: dv_go = 1'b1;
         kbe_pkg::ST_UP_GO: up_go = 1'b1;
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_data_in.updated   = upd_ff;
      rsp_data_in.bias_x    = bias_ff[0];
      rsp_data_in.bias_y    = bias_ff[1];
      rsp_data_in.bias_z    = bias_ff[2];
      rsp_data_in.cov_trace = {1'b0, ev_ff, 1'b0} + {2'b00, ev_ff};
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == kbe_pkg::ST_OUT && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kbe_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         r_base_ff    <= kbe_pkg::R_BASE_RESET;
         r_gain_ff    <= kbe_pkg::R_GAIN_RESET;
         gravity_ff   <= kbe_pkg::GRAVITY_RESET;
         pnoise_ff    <= kbe_pkg::PNOISE_RESET;
         for (int i = 0; i < 3; i++) begin
            bias_ff[i] <= '0;
         end
         ev_ff        <= kbe_pkg::COV_RESET;
         prev_time_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               kbe_pkg::CSR_R_BASE:        r_base_ff  <= csr_wdata[23:0];
               kbe_pkg::CSR_R_GAIN:        r_gain_ff  <= csr_wdata[23:0];
               kbe_pkg::CSR_GRAVITY:       gravity_ff <= csr_wdata[GW-1:0];
               kbe_pkg::CSR_PROCESS_NOISE: pnoise_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (req_accept) begin
            prev_time_ff <= req_data.sample_time;
         end
         if (state_ff == kbe_pkg::ST_WRITE) begin
            for (int i = 0; i < 3; i++) begin
               bias_ff[i] <= bias_new[i];
            end
            ev_ff <= ev_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         acc_ff[0] <= req_data.accel_x;
         acc_ff[1] <= req_data.accel_y;
         acc_ff[2] <= req_data.accel_z;
         upd_ff    <= !skip;
      end
      if (state_ff == kbe_pkg::ST_OUT && out_free) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_skip_goes_out: assert property (@(posedge clock) disable iff (reset)
      (req_accept && skip) |=> state_ff == kbe_pkg::ST_OUT)
      else $error("skipped transaction did not go to output");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == kbe_pkg::ST_OUT)
      else $error("response raised outside output state");

   a_cov_write: assert property (@(posedge clock) disable iff (reset)
      (!$stable(ev_ff) && !$past(reset)) |-> $past(state_ff) == kbe_pkg::ST_WRITE)
      else $error("covariance changed outside write state");

   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kbe_pkg::ST_UP_GO) |-> (k <= K_ONE))
      else $error("gain above one");

   a_skip_no_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kbe_pkg::ST_WRITE) |-> upd_ff)
      else $error("skipped transaction reached write state");

endmodule
